/* src/scan_result_topk_dedup_table_macros.svh */
// Assertion macros shared by the table's checker files.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef SCAN_RESULT_TOPK_DEDUP_TABLE_MACROS_SVH
`define SCAN_RESULT_TOPK_DEDUP_TABLE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define SRTDT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srtdt assertion failed");

// Next-cycle implication, disabled in reset
`define SRTDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srtdt assertion failed");

`endif

/* src/srtdt_pkg.sv */
// Types, codes and compare functions for the scan result top-k table.
// Depends on nothing; used by the cell, the top level and the checker.
`default_nettype none

package srtdt_pkg;

   localparam int MAX_RECORDS_DEF = 16;
   localparam int NAME_BYTES      = 32;
   localparam int NAME_BITS       = 256;

   // opcodes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_OFFER  = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // security classes
   localparam logic [1:0] SEC_UNSUPPORTED = 2'd2;
   localparam logic [1:0] SEC_RESERVED    = 2'd3;

   // result status codes
   localparam logic [2:0] ST_CLEARED  = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_UPDATED  = 3'd2;
   localparam logic [2:0] ST_KEPT     = 3'd3;
   localparam logic [2:0] ST_EVICTED  = 3'd4;
   localparam logic [2:0] ST_DROPPED  = 3'd5;
   localparam logic [2:0] ST_IGNORED  = 3'd6;
   localparam logic [2:0] ST_RECORD   = 3'd7;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [63:0]       ssid_word_0;
      logic [63:0]       ssid_word_1;
      logic [63:0]       ssid_word_2;
      logic [63:0]       ssid_word_3;
      logic [5:0]        ssid_len;
      logic signed [7:0] rssi_in;
      logic [7:0]        channel_in;
      logic [1:0]        security_in;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [63:0]       out_ssid_word_0;
      logic [63:0]       out_ssid_word_1;
      logic [63:0]       out_ssid_word_2;
      logic [63:0]       out_ssid_word_3;
      logic [5:0]        out_ssid_len;
      logic signed [7:0] out_rssi;
      logic [7:0]        out_channel;
      logic [1:0]        out_security;
      logic              truncated;
      logic [4:0]        record_count;
      logic              last;
   } rsp_type;

   // one held record; name byte 0 is the top byte
   typedef struct packed {
      logic [NAME_BITS-1:0] name;
      logic [5:0]           len;
      logic signed [7:0]    rssi;
      logic [7:0]           chan;
      logic [1:0]           sec;
   } rec_type;

   // chain operation broadcast to every cell
   typedef enum logic [1:0] {
      PH_HOLD,
      PH_DELETE,
      PH_INSERT,
      PH_ROTATE
   } phase_type;

   // true if a sorts ahead of b; names are zero padded past their length
   function automatic logic rec_before(rec_type a, rec_type b);
      logic r;
      if (a.rssi != b.rssi) begin
         r = (a.rssi > b.rssi);
      end else if (a.name != b.name) begin
         r = (a.name < b.name);
      end else if (a.len != b.len) begin
         r = (a.len < b.len);
      end else begin
         r = (a.sec < b.sec);
      end
      return r;
   endfunction

   function automatic logic same_key(rec_type a, rec_type b);
      return (a.len == b.len) && (a.sec == b.sec) && (a.name == b.name);
   endfunction

endpackage

`default_nettype wire

/* src/srtdt_cell.sv */
// One slot of the sorted record chain: holds a record and trades it with neighbors.
// Depends on srtdt_pkg.
`default_nettype none

module srtdt_cell (
   input  wire                    clock,
   input  srtdt_pkg::phase_type   phase,
   input  srtdt_pkg::rec_type     cand,
   input  wire                    valid,
   input  wire                    left_before,
   input  wire                    left_del,
   input  srtdt_pkg::rec_type     left_rec,
   input  srtdt_pkg::rec_type     right_rec,
   output srtdt_pkg::rec_type     rec_out,
   output logic                   before_out,
   output logic                   del_out,
   output logic                   match_out,
   output logic                   stronger_out
);
   import srtdt_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;

   // compare the broadcast candidate with the held record; empty slots sort last
   always_comb begin
      before_out   = !valid || rec_before(cand, rec_ff);
      match_out    = valid && same_key(cand, rec_ff);
      stronger_out = match_out && (cand.rssi > rec_ff.rssi);
      del_out      = match_out || left_del;
   end

   // pick the next record for this slot
   always_comb begin
      rec_in = rec_ff;
      unique case (phase)
         PH_HOLD: begin
            rec_in = rec_ff;
         end
         PH_DELETE: begin
            if (del_out) begin
               rec_in = right_rec;
            end
         end
         PH_INSERT: begin
            if (left_before) begin
               rec_in = left_rec;
            end else if (before_out) begin
               rec_in = cand;
            end
         end
         PH_ROTATE: begin
            rec_in = right_rec;
         end
         default: begin
            rec_in = rec_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec_out = rec_ff;

endmodule

`default_nettype wire

/* src/scan_result_topk_dedup_table.sv */
// Top level of the scan result top-k table: control, chain of record cells, CSR.
// Depends on srtdt_pkg and srtdt_cell.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+----------------------------------
//   request  | start, busy, req_item    | taken when start and not busy
//   result   | rsp_strobe, rsp_item     | one cycle per result, no stall
//   config   | psel..pready             | APB write, capacity at address 0
//
// Results are registered and appear in the cycle after the step that makes them.
// Clear, ignored and unknown items leave busy low. An offer of nonzero length is
// busy for a compare step, a delete step when a held key gets a stronger rssi,
// and an insert step unless the offer is kept or dropped. A finish rotates the
// whole chain of MAX_RECORDS cells once, emitting one held record per cycle.
// Synchronous reset empties the table and sets capacity 16.
`default_nettype none

module scan_result_topk_dedup_table #(
   parameter int MAX_RECORDS = srtdt_pkg::MAX_RECORDS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  srtdt_pkg::req_type   req_item,
   output logic                 rsp_strobe,
   output srtdt_pkg::rsp_type   rsp_item,
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire  [2:0]           paddr,
   input  wire  [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import srtdt_pkg::*;

   localparam int CW = $clog2(MAX_RECORDS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DELETE,
      S_INSERT,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     kidx_ff, kidx_in;
   logic              trunc_ff, trunc_in;
   logic [4:0]        cap_ff;
   logic [CW-1:0]     cap_eff;
   rec_type           cand_ff, cand_in;
   rec_type           norm_rec;
   logic [2:0]        ins_status_ff, ins_status_in;
   logic              rsp_strobe_ff;
   rsp_type           rsp_ff, rsp_in;
   phase_type         phase;

   rec_type           rec_w [MAX_RECORDS];
   logic [MAX_RECORDS-1:0] valid_w, before_w, del_w, match_w, stronger_w, tail_w;
   logic              weak_before;

   // respond fields set by the control logic
   logic              resp;
   logic [2:0]        resp_status;
   logic              resp_has_rec;
   logic              resp_last;

   // config port: capacity register at index 0
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 5'd16;
      end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
         cap_ff <= pwdata[4:0];
      end
   end
   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {27'd0, cap_ff} : 32'd0;

   // clamp capacity to 1..MAX_RECORDS
   always_comb begin
      if (cap_ff == 5'd0) begin
         cap_eff = CW'(1);
      end else if (int'(cap_ff) > MAX_RECORDS) begin
         cap_eff = CW'(MAX_RECORDS);
      end else begin
         cap_eff = CW'(cap_ff);
      end
   end

   // normalize an offered record: saturate length, zero bytes past it, reserved security to unsupported
   always_comb begin
      logic [5:0]           len_sat;
      logic [NAME_BITS-1:0] raw;
      len_sat = (int'(req_item.ssid_len) > NAME_BYTES) ? 6'(NAME_BYTES) : req_item.ssid_len;
      raw = {req_item.ssid_word_0, req_item.ssid_word_1,
             req_item.ssid_word_2, req_item.ssid_word_3};
      for (int b = 0; b < NAME_BYTES; b++) begin
         norm_rec.name[NAME_BITS-1-8*b -: 8] = (b < int'(len_sat)) ?
            raw[NAME_BITS-1-8*b -: 8] : 8'd0;
      end
      norm_rec.len  = len_sat;
      norm_rec.rssi = req_item.rssi_in;
      norm_rec.chan = req_item.channel_in;
      norm_rec.sec  = (req_item.security_in == SEC_RESERVED) ?
                      SEC_UNSUPPORTED : req_item.security_in;
   end

   // chain of record cells
   for (genvar j = 0; j < MAX_RECORDS; j++) begin : g_cell
      logic lb, ld;
      rec_type lrec, rrec;
      assign valid_w[j] = (count_ff > CW'(j));
      if (j == 0) begin : g_head
         assign lb   = 1'b0;
         assign ld   = 1'b0;
         assign lrec = rec_w[0];
      end else begin : g_body
         assign lb   = before_w[j-1];
         assign ld   = del_w[j-1];
         assign lrec = rec_w[j-1];
      end
      if (j == MAX_RECORDS - 1) begin : g_tail
         assign rrec      = rec_w[0];
         assign tail_w[j] = valid_w[j];
      end else begin : g_mid
         assign rrec      = rec_w[j+1];
         assign tail_w[j] = valid_w[j] && !valid_w[j+1];
      end
      srtdt_cell u_cell (
         .clock        (clock),
         .phase        (phase),
         .cand         (cand_ff),
         .valid        (valid_w[j]),
         .left_before  (lb),
         .left_del     (ld),
         .left_rec     (lrec),
         .right_rec    (rrec),
         .rec_out      (rec_w[j]),
         .before_out   (before_w[j]),
         .del_out      (del_w[j]),
         .match_out    (match_w[j]),
         .stronger_out (stronger_w[j])
      );
   end

   // candidate orders ahead of the weakest held record (last valid cell)
   assign weak_before = |(before_w & tail_w);

   // drive the chain from the control state
   always_comb begin
      unique case (state_ff)
         S_DELETE: phase = PH_DELETE;
         S_INSERT: phase = PH_INSERT;
         S_EMIT:   phase = PH_ROTATE;
         default:  phase = PH_HOLD;
      endcase
   end

   // control: next state, table counters and result
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      kidx_in       = kidx_ff;
      trunc_in      = trunc_ff;
      cand_in       = cand_ff;
      ins_status_in = ins_status_ff;
      resp          = 1'b0;
      resp_status   = ST_IGNORED;
      resp_has_rec  = 1'b0;
      resp_last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_item.opcode)
                  OP_CLEAR: begin
                     count_in    = '0;
                     trunc_in    = 1'b0;
                     resp        = 1'b1;
                     resp_status = ST_CLEARED;
                  end
                  OP_OFFER: begin
                     if (req_item.ssid_len == 6'd0) begin
                        resp        = 1'b1;
                        resp_status = ST_IGNORED;
                     end else begin
                        cand_in  = norm_rec;
                        state_in = S_CHECK;
                     end
                  end
                  OP_FINISH: begin
                     if (count_ff == '0) begin
                        resp        = 1'b1;
                        resp_status = ST_RECORD;
                     end else begin
                        kidx_in  = '0;
                        state_in = S_EMIT;
                     end
                  end
                  default: begin
                     resp        = 1'b1;
                     resp_status = ST_IGNORED;
                  end
               endcase
            end
         end
         S_CHECK: begin
            priority if (|match_w) begin
               if (|stronger_w) begin
                  ins_status_in = ST_UPDATED;
                  state_in      = S_DELETE;
               end else begin
                  resp        = 1'b1;
                  resp_status = ST_KEPT;
                  state_in    = S_IDLE;
               end
            end else if (count_ff < cap_eff) begin
               ins_status_in = ST_INSERTED;
               state_in      = S_INSERT;
            end else begin
               trunc_in = 1'b1;
               if (weak_before) begin
                  ins_status_in = ST_EVICTED;
                  state_in      = S_INSERT;
               end else begin
                  resp        = 1'b1;
                  resp_status = ST_DROPPED;
                  state_in    = S_IDLE;
               end
            end
         end
         S_DELETE: begin
            // pull the stale entry out; the insert puts the fresh one back
            count_in = count_ff - CW'(1);
            state_in = S_INSERT;
         end
         S_INSERT: begin
            if (ins_status_ff != ST_EVICTED) begin
               count_in = count_ff + CW'(1);
            end
            resp        = 1'b1;
            resp_status = ins_status_ff;
            state_in    = S_IDLE;
         end
         S_EMIT: begin
            // head cell holds the next record in order while the ring turns
            if (kidx_ff < count_ff) begin
               resp         = 1'b1;
               resp_status  = ST_RECORD;
               resp_has_rec = 1'b1;
               resp_last    = (kidx_ff == count_ff - CW'(1));
            end
            kidx_in = kidx_ff + CW'(1);
            if (kidx_ff == CW'(MAX_RECORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // assemble the result item
      rsp_in = '0;
      rsp_in.status = resp_status;
      if (resp_has_rec) begin
         rsp_in.out_ssid_word_0 = rec_w[0].name[255:192];
         rsp_in.out_ssid_word_1 = rec_w[0].name[191:128];
         rsp_in.out_ssid_word_2 = rec_w[0].name[127:64];
         rsp_in.out_ssid_word_3 = rec_w[0].name[63:0];
         rsp_in.out_ssid_len    = rec_w[0].len;
         rsp_in.out_rssi        = rec_w[0].rssi;
         rsp_in.out_channel     = rec_w[0].chan;
         rsp_in.out_security    = rec_w[0].sec;
      end
      rsp_in.truncated    = trunc_in;
      rsp_in.record_count = 5'(count_in);
      rsp_in.last         = resp_last;
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         kidx_ff       <= '0;
         trunc_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         kidx_ff       <= kidx_in;
         trunc_ff      <= trunc_in;
         rsp_strobe_ff <= resp;
      end
      cand_ff       <= cand_in;
      ins_status_ff <= ins_status_in;
      rsp_ff        <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

/* src/srtdt_checker.sv */
// Port-level checks for the scan result top-k table, bound to the top level.
// Depends on srtdt_pkg and scan_result_topk_dedup_table_macros.svh.
`default_nettype none

`include "scan_result_topk_dedup_table_macros.svh"

module srtdt_checker #(
   parameter int MAX_RECORDS = srtdt_pkg::MAX_RECORDS_DEF
) (
   input wire                 clock,
   input wire                 reset,
   input wire                 start,
   input wire                 busy,
   input srtdt_pkg::req_type  req_item,
   input wire                 rsp_strobe,
   input srtdt_pkg::rsp_type  rsp_item
);
   import srtdt_pkg::*;

   // a clear gives an empty, untruncated table on the next cycle
   `SRTDT_ASSERT_NEXT(a_clear_resp, clock, reset, start && !busy && (req_item.opcode == OP_CLEAR), rsp_strobe && (rsp_item.status == ST_CLEARED) && (rsp_item.record_count == 5'd0) && !rsp_item.truncated)

   // every result except a record is the only one of its item
   `SRTDT_ASSERT_NOW(a_single_last, clock, reset, rsp_strobe && (rsp_item.status != ST_RECORD), rsp_item.last)

   // drop and evict only happen on a full table, which sets the flag
   `SRTDT_ASSERT_NOW(a_full_trunc, clock, reset, rsp_strobe && ((rsp_item.status == ST_DROPPED) || (rsp_item.status == ST_EVICTED)), rsp_item.truncated && (rsp_item.record_count != 5'd0))

   // the held count never exceeds the built depth
   `SRTDT_ASSERT_NOW(a_count_bound, clock, reset, rsp_strobe, int'(rsp_item.record_count) <= MAX_RECORDS)

endmodule

bind scan_result_topk_dedup_table srtdt_checker #(.MAX_RECORDS(MAX_RECORDS)) u_srtdt_checker (.*);

`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for the scan result top-k table: directed and random items.
// Depends on srtdt_pkg and scan_result_topk_dedup_table; predicts every result.
`timescale 1ns / 100ps

module tb_top;
   import srtdt_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE      = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_strobe;
   rsp_type rsp_item;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   scan_result_topk_dedup_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // table copy kept by the bench
   rec_type   held [DEPTH];
   int        held_count;
   bit        trunc_flag;
   bit [4:0]  capacity_reg;
   rsp_type   expected_results[$];

   int  cycle_count, mismatch_count, item_count, result_count;
   bit  no_idle;
   logic [255:0] name_pool [8];

   // order: negative if a sorts ahead of b
   function automatic int rank(rec_type a, rec_type b);
      int n;
      if (a.rssi != b.rssi) return (a.rssi > b.rssi) ? -1 : 1;
      n = (a.len < b.len) ? a.len : b.len;
      for (int i = 0; i < n; i++) begin
         if (a.name[255-8*i -: 8] != b.name[255-8*i -: 8])
            return (a.name[255-8*i -: 8] < b.name[255-8*i -: 8]) ? -1 : 1;
      end
      if (a.len != b.len) return (a.len < b.len) ? -1 : 1;
      if (a.sec != b.sec) return (a.sec < b.sec) ? -1 : 1;
      return 0;
   endfunction

   function automatic rsp_type make_result(logic [2:0] st, rec_type r, bit has_rec, bit fin);
      rsp_type o;
      o = '0;
      o.status = st;
      if (has_rec) begin
         {o.out_ssid_word_0, o.out_ssid_word_1, o.out_ssid_word_2, o.out_ssid_word_3} = r.name;
         o.out_ssid_len = r.len;
         o.out_rssi     = r.rssi;
         o.out_channel  = r.chan;
         o.out_security = r.sec;
      end
      o.truncated    = trunc_flag;
      o.record_count = held_count[4:0];
      o.last         = fin;
      return o;
   endfunction

   // offer one record to the bench table, return the status
   function automatic logic [2:0] offer_record(req_type it);
      rec_type c, weakest;
      int len, cap, wi;
      len = (it.ssid_len > NAME_BYTES) ? NAME_BYTES : it.ssid_len;
      if (len == 0) return ST_IGNORED;
      c.name = {it.ssid_word_0, it.ssid_word_1, it.ssid_word_2, it.ssid_word_3};
      for (int i = len; i < NAME_BYTES; i++) c.name[255-8*i -: 8] = 8'h00;
      c.len  = len[5:0];
      c.rssi = it.rssi_in;
      c.chan = it.channel_in;
      c.sec  = (it.security_in == SEC_RESERVED) ? SEC_UNSUPPORTED : it.security_in;
      // refresh a matching key
      for (int i = 0; i < held_count; i++) begin
         if (held[i].len == c.len && held[i].sec == c.sec && held[i].name == c.name) begin
            if (c.rssi > held[i].rssi) begin
               held[i] = c;
               return ST_UPDATED;
            end
            return ST_KEPT;
         end
      end
      cap = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : capacity_reg);
      if (held_count < cap) begin
         held[held_count] = c;
         held_count++;
         return ST_INSERTED;
      end
      // full table: find the weakest held record
      trunc_flag = 1'b1;
      wi = 0;
      weakest = held[0];
      for (int i = 1; i < held_count; i++) begin
         if (rank(weakest, held[i]) < 0) begin
            weakest = held[i];
            wi = i;
         end
      end
      if (rank(c, weakest) < 0) begin
         held[wi] = c;
         return ST_EVICTED;
      end
      return ST_DROPPED;
   endfunction

   // work out every result of one accepted item
   function automatic void predict_item(req_type it);
      rec_type r, blank;
      int p;
      blank = '0;
      case (it.opcode)
         OP_CLEAR: begin
            held_count = 0;
            trunc_flag = 1'b0;
            expected_results.push_back(make_result(ST_CLEARED, blank, 0, 1));
         end
         OP_OFFER: begin
            logic [2:0] st;
            st = offer_record(it);
            expected_results.push_back(make_result(st, blank, 0, 1));
         end
         OP_FINISH: begin
            if (held_count == 0) begin
               expected_results.push_back(make_result(ST_RECORD, blank, 0, 1));
            end else begin
               // insertion sort, then emit in order
               for (int i = 1; i < held_count; i++) begin
                  r = held[i];
                  p = i;
                  while (p > 0 && rank(r, held[p-1]) < 0) begin
                     held[p] = held[p-1];
                     p--;
                  end
                  held[p] = r;
               end
               for (int i = 0; i < held_count; i++)
                  expected_results.push_back(
                     make_result(ST_RECORD, held[i], 1, i + 1 == held_count));
            end
         end
         default: expected_results.push_back(make_result(ST_IGNORED, blank, 0, 1));
      endcase
   endfunction

   // check each result against the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_r;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
      if (!reset && rsp_strobe) begin
         result_count++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_item);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_item.status !== exp_r.status
                || rsp_item.out_ssid_word_0 !== exp_r.out_ssid_word_0
                || rsp_item.out_ssid_word_1 !== exp_r.out_ssid_word_1
                || rsp_item.out_ssid_word_2 !== exp_r.out_ssid_word_2
                || rsp_item.out_ssid_word_3 !== exp_r.out_ssid_word_3
                || rsp_item.out_ssid_len !== exp_r.out_ssid_len
                || rsp_item.out_rssi !== exp_r.out_rssi
                || rsp_item.out_channel !== exp_r.out_channel
                || rsp_item.out_security !== exp_r.out_security
                || rsp_item.truncated !== exp_r.truncated
                || rsp_item.record_count !== exp_r.record_count
                || rsp_item.last !== exp_r.last) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch at cycle %0d", cycle_count);
                  $display("  expected %h", exp_r);
                  $display("  actual   %h", rsp_item);
               end
            end
         end
      end
   end

   // send one item; caller is at a rising edge
   task automatic send_item(req_type it);
      bit was_busy;
      if (!no_idle && $urandom_range(99) < 29) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      forever begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
         if (!was_busy) break;
      end
      predict_item(it);
      item_count++;
   endtask

   // hold off until every expected result has come and the block is idle
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(bit [4:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= '0;
      csr_pwdata  <= {27'd0, value};
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      capacity_reg = value;
      @(posedge clock);
   endtask

   function automatic req_type make_item(logic [1:0] op, logic [255:0] nm, logic [5:0] len,
                                         logic signed [7:0] rssi, logic [7:0] chan,
                                         logic [1:0] sec);
      req_type it;
      it.opcode = op;
      {it.ssid_word_0, it.ssid_word_1, it.ssid_word_2, it.ssid_word_3} = nm;
      it.ssid_len    = len;
      it.rssi_in     = rssi;
      it.channel_in  = chan;
      it.security_in = sec;
      return it;
   endfunction

   function automatic logic [255:0] random_name();
      logic [255:0] nm;
      for (int i = 0; i < 8; i++) nm[32*i +: 32] = $urandom;
      return nm;
   endfunction

   // extremes of every field, every opcode, duplicates and the empty marker
   task automatic test_directed();
      logic [255:0] ones = '1;
      logic [255:0] abc  = {8'h61, 8'h62, 8'h63, 232'h0};
      send_item(make_item(OP_FINISH, '0, 0, 0, 0, 0));
      send_item(make_item(OP_OFFER, ones, 0, 8'sd50, 8'd1, 2'd0));
      send_item(make_item(OP_OFFER, ones, 6'd63, 8'sd127, 8'd255, SEC_RESERVED));
      send_item(make_item(OP_OFFER, ones, 6'd32, 8'sd100, 8'd7, 2'd2));
      send_item(make_item(OP_OFFER, abc | {24'h0, 232'h1}, 6'd3, -8'sd128, 8'd0, 2'd0));
      send_item(make_item(OP_OFFER, abc, 6'd2, -8'sd40, 8'd3, 2'd1));
      send_item(make_item(OP_OFFER, abc, 6'd2, -8'sd60, 8'd4, 2'd1));
      send_item(make_item(OP_OFFER, abc, 6'd2, -8'sd20, 8'd5, 2'd1));
      send_item(make_item(OP_OFFER, abc, 6'd2, -8'sd40, 8'd6, 2'd0));
      send_item(make_item(OP_OFFER, abc, 6'd1, -8'sd40, 8'd6, 2'd0));
      send_item(make_item(2'd3, ones, 6'd5, 8'sd1, 8'd1, 2'd1));
      send_item(make_item(OP_FINISH, '0, 0, 0, 0, 0));
      send_item(make_item(OP_FINISH, '0, 0, 0, 0, 0));
      send_item(make_item(OP_CLEAR, ones, 6'd63, -8'sd1, 8'd255, 2'd3));
      send_item(make_item(OP_FINISH, '0, 0, 0, 0, 0));
   endtask

   // capacity at its extremes, including lowering below the held count
   task automatic test_capacity();
      write_capacity(5'd1);
      send_item(make_item(OP_OFFER, name_pool[0], 6'd4, 8'sd10, 8'd1, 2'd0));
      send_item(make_item(OP_OFFER, name_pool[1], 6'd4, 8'sd20, 8'd2, 2'd0));
      send_item(make_item(OP_OFFER, name_pool[2], 6'd4, 8'sd5, 8'd3, 2'd0));
      send_item(make_item(OP_FINISH, '0, 0, 0, 0, 0));
      write_capacity(5'd31);
      for (int i = 0; i < DEPTH + 2; i++)
         send_item(make_item(OP_OFFER, random_name(), $urandom_range(1, 32),
                             $urandom, $urandom, $urandom_range(0, 2)));
      send_item(make_item(OP_FINISH, '0, 0, 0, 0, 0));
      write_capacity(5'd0);
      send_item(make_item(OP_OFFER, random_name(), 6'd8, 8'sd127, 8'd9, 2'd1));
      send_item(make_item(OP_FINISH, '0, 0, 0, 0, 0));
      write_capacity(5'd16);
      send_item(make_item(OP_CLEAR, '0, 0, 0, 0, 0));
   endtask

   // random mix: offers from a small name pool so keys repeat
   task automatic test_random(int count);
      req_type it;
      int pick;
      for (int n = 0; n < count; n++) begin
         no_idle = (n >= 100 && n < 160);
         if (n % 60 == 59) write_capacity($urandom_range(0, 31));
         pick = $urandom_range(99);
         it = make_item(OP_OFFER, name_pool[$urandom_range(0, 7)], $urandom_range(1, 40),
                        $urandom, $urandom, $urandom);
         if (pick < 15) it.ssid_word_0 = {$urandom, $urandom};
         if (pick < 5) it = make_item(OP_OFFER, random_name(), $urandom_range(1, 63),
                                       $urandom, $urandom, $urandom);
         if (pick >= 80 && pick < 90) it.opcode = OP_FINISH;
         else if (pick >= 90 && pick < 94) it.opcode = OP_CLEAR;
         else if (pick >= 94 && pick < 96) it.opcode = 2'd3;
         else if (pick >= 96) it.ssid_len = '0;
         send_item(it);
         if (n == 200) wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      held_count     = 0;
      trunc_flag     = 1'b0;
      capacity_reg   = 5'd16;
      cycle_count    = 0;
      mismatch_count = 0;
      item_count     = 0;
      result_count   = 0;
      no_idle        = 1'b0;
      for (int i = 0; i < 8; i++) name_pool[i] = random_name();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_capacity();
      test_random(300);
      wait_drained();

      if (expected_results.size() != 0) mismatch_count++;
      $display("%0d items sent, %0d results checked, capacities 0 to 31 exercised",
               item_count, result_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
